@@ rtl/core/wtam_pkg.sv @@
// Shared types, widths, register codes and helpers for the wall texel address mapper.
package wtam_pkg;

    // Field widths.
    localparam int ROW_W    = 12;
    localparam int COL_W    = 12;
    localparam int LH_W     = 16;
    localparam int SPAN_W   = 13;
    localparam int SH_W     = 13;
    localparam int TSIZE_W  = 11;
    localparam int RB_W     = 14;
    localparam int BPP_W    = 3;
    localparam int TEX_W    = 10;
    localparam int OFF_W    = 24;

    // Vertical divider: ten quotient bits, dividend is num (16 bits) times height (11 bits).
    localparam int QUO_W    = TEX_W;
    localparam int NUM_W    = 16;
    localparam int DIVD_W   = NUM_W + TSIZE_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd4;

    // Configuration register set.
    typedef struct packed {
        logic [SH_W-1:0]    view_height;
        logic [TSIZE_W-1:0] texture_width;
        logic [TSIZE_W-1:0] texture_height;
        logic [RB_W-1:0]    row_bytes;
        logic [BPP_W-1:0]   bytes_per_pixel;
    } cfg_t;

    // Item as it travels through the divider stages.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [TEX_W-1:0]  tx;
        logic [LH_W-1:0]   lh;
        logic              neg;
        logic              sat;
        logic [DIVD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } div_item_t;

    // Largest legal index for a texture dimension: min(size-1, 1023), zero for size zero.
    function automatic logic [TEX_W-1:0] index_top(input logic [TSIZE_W-1:0] size);
        logic [TSIZE_W-1:0] top;
        top = size - TSIZE_W'(1);
        if (size == '0)
        begin
            return '0;
        end
        else if (top[TSIZE_W-1])
        begin
            return '1;
        end
        else
        begin
            return top[TEX_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/wtam_front.sv @@
// Front stages: span check, fraction mirror, numerator, both multiplies and the overflow test.
module wtam_front
    import wtam_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  cfg_t                cfg,
    input  logic                in_valid,
    input  logic [ROW_W-1:0]    pixel_row,
    input  logic [COL_W-1:0]    screen_column,
    input  logic [LH_W-1:0]     slice_height,
    input  logic [SPAN_W-1:0]   span_start,
    input  logic [SPAN_W-1:0]   span_end,
    input  logic                hit_side,
    input  logic                ray_x_negative,
    input  logic                ray_y_positive,
    input  logic [31:0]         hit_pos_x,
    input  logic [31:0]         hit_pos_y,
    output logic                out_valid,
    output div_item_t           out_item
);

    localparam int M_W   = FRAC_BITS + 1;
    localparam int TXP_W = M_W + TSIZE_W;
    localparam int SUM_W = LH_W + 2;

    // Stage 1 signals.
    logic                 in_span;
    logic [FRAC_BITS-1:0] frac;
    logic                 mirror;
    logic [M_W-1:0]       m_next;
    logic [SUM_W-1:0]     num_next;

    logic                 v1_reg;
    logic [ROW_W-1:0]     row1_reg;
    logic [COL_W-1:0]     col1_reg;
    logic [LH_W-1:0]      lh1_reg;
    logic [M_W-1:0]       m1_reg;
    logic                 neg1_reg;
    logic [NUM_W-1:0]     num1_reg;

    // Stage 2 signals.
    logic [TXP_W-1:0]     txp_next;
    logic                 v2_reg;
    logic [ROW_W-1:0]     row2_reg;
    logic [COL_W-1:0]     col2_reg;
    logic [LH_W-1:0]      lh2_reg;
    logic                 neg2_reg;
    logic [TSIZE_W-1:0]   txraw2_reg;
    logic [DIVD_W-1:0]    nd2_reg;

    // Stage 3 signals.
    logic [TEX_W-1:0]     top_x;
    logic [DIVD_W-1:0]    ovf_bound;
    logic                 v3_reg;
    div_item_t            item3_reg;
    div_item_t            item3_next;

    // Stage 1: span test, fraction select and mirror, vertical numerator.
    assign in_span = ({1'b0, pixel_row} >= span_start) && ({1'b0, pixel_row} < span_end);
    assign frac    = hit_side ? hit_pos_x[FRAC_BITS-1:0] : hit_pos_y[FRAC_BITS-1:0];
    assign mirror  = hit_side ? ray_y_positive : ray_x_negative;
    assign m_next  = mirror ? ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac}) : {1'b0, frac};
    assign num_next = SUM_W'(pixel_row) - SUM_W'(cfg.view_height[SH_W-1:1])
                    + SUM_W'(slice_height[LH_W-1:1]);

    // Stage 2: scale the fraction by the width, numerator by the height.
    assign txp_next = TXP_W'(m1_reg) * TXP_W'(cfg.texture_width);

    // Stage 3: saturate the column, flag quotients that cannot fit in ten bits.
    assign top_x     = index_top(cfg.texture_width);
    assign ovf_bound = {1'b0, lh2_reg, {QUO_W{1'b0}}};

    always_comb
    begin
        item3_next.row = row2_reg;
        item3_next.col = col2_reg;
        item3_next.tx  = (txraw2_reg > {1'b0, top_x}) ? top_x : txraw2_reg[TEX_W-1:0];
        item3_next.lh  = lh2_reg;
        item3_next.neg = neg2_reg;
        item3_next.sat = (nd2_reg >= ovf_bound);
        item3_next.rem = nd2_reg;
        item3_next.quo = '0;
    end

    // Valid bits; rows outside the span are dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid && in_span;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row1_reg   <= pixel_row;
            col1_reg   <= screen_column;
            lh1_reg    <= slice_height;
            m1_reg     <= m_next;
            neg1_reg   <= num_next[SUM_W-1];
            num1_reg   <= num_next[NUM_W-1:0];

            row2_reg   <= row1_reg;
            col2_reg   <= col1_reg;
            lh2_reg    <= lh1_reg;
            neg2_reg   <= neg1_reg;
            txraw2_reg <= txp_next[FRAC_BITS +: TSIZE_W];
            nd2_reg    <= DIVD_W'(num1_reg) * DIVD_W'(cfg.texture_height);

            item3_reg  <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

@@ rtl/core/wtam_div_stage.sv @@
// One restoring-division stage: settles one quotient bit of the texture row.
module wtam_div_stage
    import wtam_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_item_t in_item,
    output logic      out_valid,
    output div_item_t out_item
);

    logic [DIVD_W-1:0] trial;
    logic              fits;
    logic              valid_reg;
    div_item_t         item_reg;
    div_item_t         item_next;

    // Compare against the divisor shifted to this bit and subtract when it fits.
    assign trial = {{(DIVD_W-LH_W){1'b0}}, in_item.lh} << BIT;
    assign fits  = (in_item.rem >= trial);

    always_comb
    begin
        item_next = in_item;
        if (fits)
        begin
            item_next.rem      = in_item.rem - trial;
            item_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/core/wtam_back.sv @@
// Back stages: texture row clamp, byte offset products and sum, output register.
module wtam_back
    import wtam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  cfg_t                cfg,
    input  logic                in_valid,
    input  div_item_t           in_item,
    output logic                out_valid,
    output logic [ROW_W-1:0]    out_row,
    output logic [COL_W-1:0]    out_column,
    output logic [TEX_W-1:0]    texel_x,
    output logic [TEX_W-1:0]    texel_y,
    output logic [OFF_W-1:0]    texel_offset
);

    localparam int PB_W = TEX_W + BPP_W;

    logic [TEX_W-1:0] top_y;
    logic [TEX_W-1:0] ty_next;

    logic             va_reg;
    logic [ROW_W-1:0] rowa_reg;
    logic [COL_W-1:0] cola_reg;
    logic [TEX_W-1:0] txa_reg;
    logic [TEX_W-1:0] tya_reg;
    logic [OFF_W-1:0] pa_reg;
    logic [PB_W-1:0]  pb_reg;

    logic             vb_reg;
    logic [ROW_W-1:0] rowb_reg;
    logic [COL_W-1:0] colb_reg;
    logic [TEX_W-1:0] txb_reg;
    logic [TEX_W-1:0] tyb_reg;
    logic [OFF_W-1:0] offb_reg;

    // Row clamp: negative numerator gives zero, oversize quotient gives the top row.
    assign top_y = index_top(cfg.texture_height);

    always_comb
    begin
        if (in_item.neg)
        begin
            ty_next = '0;
        end
        else if (in_item.sat || (in_item.quo > top_y))
        begin
            ty_next = top_y;
        end
        else
        begin
            ty_next = in_item.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // First stage forms both offset products, second adds them into the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rowa_reg <= in_item.row;
            cola_reg <= in_item.col;
            txa_reg  <= in_item.tx;
            tya_reg  <= ty_next;
            pa_reg   <= OFF_W'(ty_next) * OFF_W'(cfg.row_bytes);
            pb_reg   <= PB_W'(in_item.tx) * PB_W'(cfg.bytes_per_pixel);

            rowb_reg <= rowa_reg;
            colb_reg <= cola_reg;
            txb_reg  <= txa_reg;
            tyb_reg  <= tya_reg;
            offb_reg <= pa_reg + OFF_W'(pb_reg);
        end
    end

    assign out_valid    = vb_reg;
    assign out_row      = rowb_reg;
    assign out_column   = colb_reg;
    assign texel_x      = txb_reg;
    assign texel_y      = tyb_reg;
    assign texel_offset = offb_reg;

endmodule

@@ rtl/core/wall_texel_address_mapper_top.sv @@
// Top level of the wall texel address mapper: stream ports, configuration registers, pipeline.
//
// Maps one wall pixel per transfer to texel coordinates and a byte offset. The pipeline
// takes a new item every cycle while the output is not stalled and has fifteen register
// stages: three front stages, ten stages of the restoring divider for the texture row
// (one quotient bit per stage), and two back stages ending in the output register. The
// whole pipeline advances whenever the output register is empty or being taken, so a
// stall on the output holds every stage in place. Rows outside the drawn span give no
// output transfer. Configuration registers are read live by the stages, so write them
// only while no item is in flight.
module wall_texel_address_mapper_top
    import wtam_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_row[11:0], screen_column[23:12], slice_height[39:24], span_start[52:40],
    // span_end[65:53], hit_pos_x[97:66], hit_pos_y[129:98], zero pad[135:130]
    input  logic [135:0]          s_tdata,
    // hit_side[0], ray_x_negative[1], ray_y_positive[2]
    input  logic [2:0]            s_tuser,

    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_row[11:0], out_column[23:12], texel_x[33:24], texel_y[43:34],
    // texel_offset[67:44], zero pad[71:68]
    output logic [71:0]           m_tdata,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int N_DIV = QUO_W;

    cfg_t             cfg_reg;
    logic             en;

    logic             div_valid [N_DIV+1];
    div_item_t        div_item  [N_DIV+1];

    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic [TEX_W-1:0] texel_x;
    logic [TEX_W-1:0] texel_y;
    logic [OFF_W-1:0] texel_offset;

    // Global advance: the output register is free or its transfer completes.
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_height     <= SH_W'(480);
            cfg_reg.texture_width   <= TSIZE_W'(64);
            cfg_reg.texture_height  <= TSIZE_W'(64);
            cfg_reg.row_bytes       <= RB_W'(256);
            cfg_reg.bytes_per_pixel <= BPP_W'(4);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VIEW_HEIGHT:     cfg_reg.view_height     <= cfg_data[SH_W-1:0];
                CFG_TEXTURE_WIDTH:   cfg_reg.texture_width   <= cfg_data[TSIZE_W-1:0];
                CFG_TEXTURE_HEIGHT:  cfg_reg.texture_height  <= cfg_data[TSIZE_W-1:0];
                CFG_ROW_BYTES:       cfg_reg.row_bytes       <= cfg_data[RB_W-1:0];
                CFG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= cfg_data[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Front stages.
    wtam_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .pixel_row      (s_tdata[11:0]),
        .screen_column  (s_tdata[23:12]),
        .slice_height   (s_tdata[39:24]),
        .span_start     (s_tdata[52:40]),
        .span_end       (s_tdata[65:53]),
        .hit_side       (s_tuser[0]),
        .ray_x_negative (s_tuser[1]),
        .ray_y_positive (s_tuser[2]),
        .hit_pos_x      (s_tdata[97:66]),
        .hit_pos_y      (s_tdata[129:98]),
        .out_valid      (div_valid[0]),
        .out_item       (div_item[0])
    );

    // Divider stages, most significant quotient bit first.
    for (genvar g = 0; g < N_DIV; g++)
    begin : g_div
        wtam_div_stage #(
            .BIT (N_DIV - 1 - g)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[g]),
            .in_item   (div_item[g]),
            .out_valid (div_valid[g+1]),
            .out_item  (div_item[g+1])
        );
    end

    // Back stages and output register.
    wtam_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg          (cfg_reg),
        .in_valid     (div_valid[N_DIV]),
        .in_item      (div_item[N_DIV]),
        .out_valid    (m_tvalid),
        .out_row      (out_row),
        .out_column   (out_column),
        .texel_x      (texel_x),
        .texel_y      (texel_y),
        .texel_offset (texel_offset)
    );

    assign m_tdata = {4'b0, texel_offset, texel_y, texel_x, out_column, out_row};

endmodule

@@ tb/sv/wall_texel_address_mapper_top_test.sv @@
// Self-checking testbench for the wall texel address mapper: directed and random pixels.
module wall_texel_address_mapper_top_test;
    import wtam_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 90;

    // One screen pixel with the hit data of its column.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [LH_W-1:0]   lh;
        logic [SPAN_W-1:0] span_lo;
        logic [SPAN_W-1:0] span_hi;
        logic              side;
        logic              xneg;
        logic              ypos;
        logic [31:0]       hit_x;
        logic [31:0]       hit_y;
    } pixel_t;

    // One texel lookup as it leaves the block.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [TEX_W-1:0] tex_x;
        logic [TEX_W-1:0] tex_y;
        logic [OFF_W-1:0] offset;
    } texel_t;

    // Scoreboard: keeps its own register copy and predicts each texel lookup.
    class texel_scoreboard;
        cfg_t   regs;
        texel_t expected_texels[$];
        int     errors;
        int     accepted_pixels;
        int     checked_texels;

        function new();
            regs.view_height     = 13'd480;
            regs.texture_width   = 11'd64;
            regs.texture_height  = 11'd64;
            regs.row_bytes       = 14'd256;
            regs.bytes_per_pixel = 3'd4;
            errors          = 0;
            accepted_pixels = 0;
            checked_texels  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_VIEW_HEIGHT:     regs.view_height     = value[SH_W-1:0];
                CFG_TEXTURE_WIDTH:   regs.texture_width   = value[TSIZE_W-1:0];
                CFG_TEXTURE_HEIGHT:  regs.texture_height  = value[TSIZE_W-1:0];
                CFG_ROW_BYTES:       regs.row_bytes       = value[RB_W-1:0];
                CFG_BYTES_PER_PIXEL: regs.bytes_per_pixel = value[BPP_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp an index to min(size-1, 1023); a zero size gives zero.
        function longint unsigned texel_limit(longint unsigned v, longint unsigned size);
            longint unsigned top;
            if (size == 0)
            begin
                return 0;
            end
            top = size - 1;
            if (top > 1023)
            begin
                top = 1023;
            end
            return (v > top) ? top : v;
        endfunction

        // Work out the lookup for an accepted pixel; rows outside the span give none.
        function void note_pixel(pixel_t p);
            longint unsigned one;
            longint unsigned frac;
            longint unsigned tx;
            longint unsigned ty;
            longint          numer;
            texel_t          t;
            accepted_pixels++;
            if ({1'b0, p.row} < p.span_lo || {1'b0, p.row} >= p.span_hi)
            begin
                return;
            end
            one  = longint'(1) << FRAC_BITS;
            frac = (p.side ? p.hit_x : p.hit_y) & (one - 1);
            // Mirror the fraction for rays that see the wall from the far side.
            if ((!p.side && p.xneg) || (p.side && p.ypos))
            begin
                frac = one - frac;
            end
            tx = texel_limit((frac * regs.texture_width) >> FRAC_BITS, regs.texture_width);
            numer = longint'(p.row) - longint'(regs.view_height / 2) + longint'(p.lh / 2);
            if (numer < 0)
            begin
                ty = 0;
            end
            else if (p.lh == 0)
            begin
                ty = texel_limit(64'hFFFF_FFFF_FFFF_FFFF, regs.texture_height);
            end
            else
            begin
                ty = texel_limit((longint'(numer) * regs.texture_height) / p.lh,
                                 regs.texture_height);
            end
            t.row    = p.row;
            t.col    = p.col;
            t.tex_x  = tx[TEX_W-1:0];
            t.tex_y  = ty[TEX_W-1:0];
            t.offset = OFF_W'(ty * regs.row_bytes + tx * regs.bytes_per_pixel);
            expected_texels.push_back(t);
        endfunction

        function int pending();
            return expected_texels.size();
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
            begin
                $display("MISMATCH: %s", what);
            end
            errors++;
        endtask

        // Compare one output transfer against the oldest expected lookup.
        task check_texel(logic [71:0] d);
            texel_t got;
            texel_t want;
            got.row    = d[11:0];
            got.col    = d[23:12];
            got.tex_x  = d[33:24];
            got.tex_y  = d[43:34];
            got.offset = d[67:44];
            if (expected_texels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result row %0d column %0d",
                                          got.row, got.col));
                return;
            end
            want = expected_texels.pop_front();
            checked_texels++;
            if (got.row != want.row)
                report_mismatch($sformatf("out_row %0d, expected %0d", got.row, want.row));
            if (got.col != want.col)
                report_mismatch($sformatf("out_column %0d, expected %0d", got.col, want.col));
            if (got.tex_x != want.tex_x)
                report_mismatch($sformatf("texel_x %0d, expected %0d (row %0d)",
                                          got.tex_x, want.tex_x, want.row));
            if (got.tex_y != want.tex_y)
                report_mismatch($sformatf("texel_y %0d, expected %0d (row %0d)",
                                          got.tex_y, want.tex_y, want.row));
            if (got.offset != want.offset)
                report_mismatch($sformatf("texel_offset %0d, expected %0d (row %0d)",
                                          got.offset, want.offset, want.row));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [135:0]          s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [71:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    texel_scoreboard sb;
    int              cycle_count = 0;
    bit              hold_done = 1'b0;
    int              settings_run = 1;

    wall_texel_address_mapper_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, one long hold-off that backs the pipeline up.
    initial
    begin
        int stall;
        int run;
        wait (rst_n);
        forever
        begin
            if (!hold_done && sb.accepted_pixels >= 40)
            begin
                hold_done = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 6);
            repeat (run - 1) @(negedge clk);
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_texel(m_tdata);
        end
    end

    function automatic pixel_t make_pixel(int row, int col, int lh, int lo, int hi,
                                          int side, int xneg, int ypos,
                                          logic [31:0] hx, logic [31:0] hy);
        pixel_t p;
        p.row     = ROW_W'(row);
        p.col     = COL_W'(col);
        p.lh      = LH_W'(lh);
        p.span_lo = SPAN_W'(lo);
        p.span_hi = SPAN_W'(hi);
        p.side    = 1'(side);
        p.xneg    = 1'(xneg);
        p.ypos    = 1'(ypos);
        p.hit_x   = hx;
        p.hit_y   = hy;
        return p;
    endfunction

    // Offer one pixel after an idle gap and wait for its transfer.
    task send_pixel(pixel_t p, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, p.hit_y, p.hit_x, p.span_hi, p.span_lo, p.lh, p.col, p.row};
        s_tuser  <= {p.ypos, p.xneg, p.side};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_pixel(p);
    endtask

    // Stop offering, let every lookup arrive, then let the pipeline empty.
    task drain_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_register(logic [CFG_IDX_W-1:0] index, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_register(index, CFG_DATA_W'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task apply_settings(int sh, int tw, int th, int rb, int bpp);
        write_register(CFG_VIEW_HEIGHT, sh);
        write_register(CFG_TEXTURE_WIDTH, tw);
        write_register(CFG_TEXTURE_HEIGHT, th);
        write_register(CFG_ROW_BYTES, rb);
        write_register(CFG_BYTES_PER_PIXEL, bpp);
        settings_run++;
    endtask

    // Random pixel: half rows of a centered wall slice, a quarter loose spans, a quarter noise.
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     kind;
        int     half_sh;
        int     lh;
        int     lo;
        int     hi;
        kind = $urandom_range(0, 99);
        lh = $urandom_range(0, 99);
        if (lh < 5)
            lh = 0;
        else if (lh < 15)
            lh = $urandom_range(0, 65535);
        else
            lh = $urandom_range(1, 3000);
        half_sh = int'(sb.regs.view_height) / 2;
        if (kind < 50)
        begin
            lo = (half_sh > lh / 2) ? half_sh - lh / 2 : 0;
            hi = half_sh + lh / 2 + 1;
            if (hi > 4096)
                hi = 4096;
            if (lo > 4095)
                lo = 4095;
            if (hi <= lo)
                hi = lo + 1;
            p = make_pixel($urandom_range(lo, (hi - 1 > 4095) ? 4095 : hi - 1),
                           $urandom_range(0, 4095), lh, lo, hi, 0, 0, 0, '0, '0);
        end
        else if (kind < 75)
        begin
            lo = $urandom_range(0, 4000);
            hi = $urandom_range(lo + 1, (lo + 600 > 4096) ? 4096 : lo + 600);
            p = make_pixel($urandom_range(lo, (hi - 1 > 4095) ? 4095 : hi - 1),
                           $urandom_range(0, 4095), lh, lo, hi, 0, 0, 0, '0, '0);
        end
        else
        begin
            p = make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), lh,
                           $urandom_range(0, 8191), $urandom_range(0, 8191),
                           0, 0, 0, '0, '0);
        end
        p.side  = 1'($urandom_range(0, 1));
        p.xneg  = 1'($urandom_range(0, 1));
        p.ypos  = 1'($urandom_range(0, 1));
        p.hit_x = $urandom;
        p.hit_y = $urandom;
        // Land exactly on a grid line now and then.
        if ($urandom_range(0, 9) == 0)
        begin
            p.hit_x[15:0] = '0;
            p.hit_y[15:0] = '0;
        end
        return p;
    endfunction

    task run_random(int count, bit no_gaps);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_pixel(random_pixel(), no_gaps ? 0 : pick_gap());
        end
    endtask

    // Directed pixels at the reset register values.
    task run_directed();
        pixel_t list[$];
        int     i;
        list.push_back(make_pixel(0, 0, 1, 0, 1, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(4095, 4095, 65535, 0, 4096, 1, 1, 1,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Mirrored zero fraction on both axes saturates to width minus one.
        list.push_back(make_pixel(240, 10, 480, 0, 480, 0, 1, 0, 32'h0, 32'h0005_0000));
        list.push_back(make_pixel(241, 11, 480, 0, 480, 1, 0, 1, 32'h0007_0000, 32'h0));
        list.push_back(make_pixel(242, 12, 480, 0, 480, 0, 0, 1, 32'h0, 32'h0001_8000));
        list.push_back(make_pixel(243, 13, 480, 0, 480, 1, 1, 0, 32'h0002_FFFF, 32'h0));
        list.push_back(make_pixel(244, 14, 480, 0, 480, 0, 1, 1, 32'h0, 32'h1234_0001));
        list.push_back(make_pixel(245, 15, 480, 0, 480, 1, 1, 1, 32'hABCD_FFFF, 32'h0));
        // Negative vertical numerator.
        list.push_back(make_pixel(0, 20, 2, 0, 10, 0, 0, 0, 32'h0, 32'h0000_4000));
        // Zero slice height.
        list.push_back(make_pixel(300, 21, 0, 0, 4096, 1, 0, 0, 32'h0000_C000, 32'h0));
        // Huge numerator against a short slice saturates the row.
        list.push_back(make_pixel(4000, 22, 10, 0, 4096, 0, 0, 0, 32'h0, 32'h0));
        // Exact center of a full-screen slice.
        list.push_back(make_pixel(240, 23, 480, 0, 480, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(0, 24, 65535, 0, 4096, 0, 0, 0, 32'h0, 32'h0));
        // Empty and inverted spans, and both span boundaries.
        list.push_back(make_pixel(100, 30, 200, 100, 100, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(150, 31, 200, 200, 100, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(180, 32, 200, 120, 180, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(120, 33, 200, 120, 180, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(119, 34, 200, 120, 180, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(4095, 35, 100, 8191, 8191, 0, 0, 0, 32'h0, 32'h0));
        list.push_back(make_pixel(4095, 36, 100, 0, 8191, 0, 0, 0, 32'h0, 32'h0));
        // Alternating bit patterns in the hit positions.
        list.push_back(make_pixel(2730, 2730, 43690, 2730, 5461, 1, 0, 0,
                                  32'hAAAA_5555, 32'h5555_AAAA));
        list.push_back(make_pixel(1365, 1365, 21845, 1365, 2730, 0, 0, 0,
                                  32'hAAAA_5555, 32'h5555_AAAA));
        for (i = 0; i < list.size(); i++)
        begin
            send_pixel(list[i], pick_gap());
        end
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_ITEMS, 1'b0);
        drain_pipeline();

        // Largest legal sizes.
        apply_settings(4096, 1024, 1024, 8192, 4);
        run_random(PHASE_ITEMS, 1'b0);
        drain_pipeline();

        // Smallest legal sizes, sent back to back.
        apply_settings(1, 1, 1, 1, 1);
        run_random(PHASE_ITEMS, 1'b1);
        drain_pipeline();

        // Zero texture sizes pin both texel coordinates to zero.
        apply_settings(600, 0, 0, 8191, 3);
        run_random(PHASE_ITEMS / 2, 1'b0);
        drain_pipeline();

        apply_settings($urandom_range(1, 4096), $urandom_range(1, 1024),
                       $urandom_range(1, 1024), $urandom_range(1, 8192),
                       $urandom_range(1, 4));
        run_random(PHASE_ITEMS, 1'b0);
        drain_pipeline();

        apply_settings($urandom_range(1, 4096), $urandom_range(1, 1024),
                       $urandom_range(1, 1024), $urandom_range(1, 8192),
                       $urandom_range(1, 4));
        run_random(PHASE_ITEMS + PHASE_ITEMS / 2, 1'b0);
        drain_pipeline();

        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d lookups never arrived", sb.pending()));
        end
        $display("Sent %0d pixels under %0d register settings; %0d texel lookups checked.",
                 sb.accepted_pixels, settings_run, sb.checked_texels);
        $display("Included mirrored hits, empty spans, zero sizes and a long output stall.");
        if (sb.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/wtam_pkg.sv
rtl/core/wtam_front.sv
rtl/core/wtam_div_stage.sv
rtl/core/wtam_back.sv
rtl/core/wall_texel_address_mapper_top.sv
tb/sv/wall_texel_address_mapper_top_test.sv
